// ===== sv/mmp_pkg.sv =====
// Shared widths, codes and controller-to-datapath types of the modular matrix product block.
package mmp_pkg;

   localparam int ELEM_W  = 30;
   localparam int MOD_W   = 31;
   localparam int LEN_W   = 5;
   localparam int IDX_W   = 4;
   localparam int OP_W    = 2;
   localparam int CSR_W   = 31;
   localparam int CSR_IDX_W = 1;
   localparam int CNT_W   = LEN_W + 1;
   localparam int PROD_W  = 2 * ELEM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_LENGTH = 1'd1;

   localparam logic [MOD_W-1:0] MODULUS_RESET      = 31'd65537;
   localparam logic [LEN_W-1:0] INNER_LENGTH_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_WR_CLIENT  = 2'd0,
      OP_WR_SERVER  = 2'd1,
      OP_RD_PRODUCT = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             wr_client;
      logic             wr_server;
      logic             capture;
      logic             rd_en;
      logic [LEN_W-1:0] rd_k;
      logic             mul_en;
      logic             acc_en;
      logic             div_load;
      logic             div_step;
      logic             finish;
   } cmd_type;

endpackage

// ===== sv/mmp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mmp_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mmp_ctrl.sv =====
// Controller state machine that sequences writes, the multiply-accumulate walk and the reduction.
module mmp_ctrl #(
   parameter int MAX_DIM = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [mmp_pkg::OP_W-1:0]  req_op,
   input  logic [mmp_pkg::LEN_W-1:0] inner_length,
   output logic                      busy,
   output logic                      rsp_valid,
   output mmp_pkg::cmd_type          cmd
);
   import mmp_pkg::*;

   localparam int LenMax   = (MAX_DIM < 31) ? MAX_DIM : 31;
   localparam int AccW     = PROD_W + ((LenMax > 1) ? $clog2(LenMax) : 0);
   localparam int DivSteps = (AccW + 1) / 2;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff;
   logic [LEN_W-1:0] eff_len;
   logic [CNT_W-1:0] len_ext, len_plus1;

   // Lengths above MAX_DIM, capped at 31, saturate to it.
   assign eff_len   = (32'(inner_length) > LenMax) ? LEN_W'(LenMax) : inner_length;
   assign len_ext   = {1'b0, eff_len};
   assign len_plus1 = len_ext + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.wr_client = (req_op == OP_WR_CLIENT);
               cmd.wr_server = (req_op == OP_WR_SERVER);
               if (req_op == OP_RD_PRODUCT) begin
                  cmd.capture = 1'b1;
                  cnt_in      = '0;
                  state_in    = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            // Step k fetches element k into the read registers; prod_ff then takes its product and acc_ff adds it.
            cmd.rd_en  = (cnt_ff < len_ext);
            cmd.rd_k   = cnt_ff[LEN_W-1:0];
            cmd.mul_en = (cnt_ff != '0) && (cnt_ff <= len_ext);
            cmd.acc_en = (cnt_ff >= CNT_W'(2)) && (cnt_ff <= len_plus1);
            if (cnt_ff == len_plus1) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DIV: begin
            cmd.div_load = (cnt_ff == '0);
            cmd.div_step = (cnt_ff != '0);
            if (cnt_ff == CNT_W'(DivSteps)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/mmp_datapath.sv =====
// Datapath: the two element stores, the multiply-accumulate and the bit-serial remainder unit.
module mmp_datapath #(
   parameter int MAX_DIM = 16
) (
   input  logic                       clock,
   input  mmp_pkg::cmd_type           cmd,
   input  logic [mmp_pkg::IDX_W-1:0]  req_inner_index,
   input  logic [mmp_pkg::IDX_W-1:0]  req_row_index,
   input  logic [mmp_pkg::IDX_W-1:0]  req_col_index,
   input  logic [mmp_pkg::ELEM_W-1:0] req_value,
   input  logic [mmp_pkg::MOD_W-1:0]  modulus,
   output logic [mmp_pkg::ELEM_W-1:0] rsp_product_value
);
   import mmp_pkg::*;

   localparam int Depth    = MAX_DIM * MAX_DIM;
   localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int LenMax   = (MAX_DIM < 31) ? MAX_DIM : 31;
   localparam int AccW     = PROD_W + ((LenMax > 1) ? $clog2(LenMax) : 0);
   localparam int DivSteps = (AccW + 1) / 2;
   localparam int DivW     = 2 * DivSteps;

   logic [IDX_W-1:0]  row_ff, col_ff;
   logic              row_ok_ff, col_ok_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [AccW-1:0]   acc_ff, acc_in;
   logic [MOD_W-1:0]  rem_ff, rem_in;
   logic [DivW-1:0]   sh_ff, sh_in;
   logic [ELEM_W-1:0] out_ff;

   logic              wr_ok_client, wr_ok_server;
   logic [AddrW-1:0]  wr_addr_client, wr_addr_server;
   logic [AddrW-1:0]  rd_addr_client, rd_addr_server;
   logic [ELEM_W-1:0] cli_rdata, srv_rdata, cli_op, srv_op;
   logic [MOD_W:0]    mod_ext, r_a, r_a_red, r_b, r_b_red;

   // Writes outside the store are dropped.
   assign wr_ok_client = (32'(req_inner_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);
   assign wr_ok_server = (32'(req_inner_index) < MAX_DIM) && (32'(req_row_index) < MAX_DIM);
   assign wr_addr_client = AddrW'(32'(req_inner_index) * MAX_DIM + 32'(req_col_index));
   assign wr_addr_server = AddrW'(32'(req_inner_index) * MAX_DIM + 32'(req_row_index));
   assign rd_addr_client = AddrW'(32'(cmd.rd_k) * MAX_DIM + 32'(col_ff));
   assign rd_addr_server = AddrW'(32'(cmd.rd_k) * MAX_DIM + 32'(row_ff));

   mmp_ram #(.WIDTH(ELEM_W), .DEPTH(Depth)) u_client_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_client && wr_ok_client),
      .wr_addr (wr_addr_client),
      .wr_data (req_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr_client),
      .rd_data (cli_rdata)
   );

   mmp_ram #(.WIDTH(ELEM_W), .DEPTH(Depth)) u_server_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_server && wr_ok_server),
      .wr_addr (wr_addr_server),
      .wr_data (req_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr_server),
      .rd_data (srv_rdata)
   );

   // An index beyond the store reads as zero.
   assign cli_op = col_ok_ff ? cli_rdata : '0;
   assign srv_op = row_ok_ff ? srv_rdata : '0;
   assign acc_in = acc_ff + AccW'(prod_ff);

   // Two restoring remainder steps per cycle, most significant bit first.
   assign mod_ext = {1'b0, modulus};
   assign r_a     = {rem_ff, sh_ff[DivW-1]};
   assign r_a_red = (r_a >= mod_ext) ? (r_a - mod_ext) : r_a;
   assign r_b     = {r_a_red[MOD_W-1:0], sh_ff[DivW-2]};
   assign r_b_red = (r_b >= mod_ext) ? (r_b - mod_ext) : r_b;
   assign rem_in  = r_b_red[MOD_W-1:0];
   assign sh_in   = {sh_ff[DivW-3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff    <= req_row_index;
         col_ff    <= req_col_index;
         row_ok_ff <= (32'(req_row_index) < MAX_DIM);
         col_ok_ff <= (32'(req_col_index) < MAX_DIM);
         acc_ff    <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(srv_op) * PROD_W'(cli_op);
      end
      if (cmd.div_load) begin
         rem_ff <= '0;
         sh_ff  <= DivW'(acc_ff);
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         sh_ff  <= sh_in;
      end
      if (cmd.finish) begin
         out_ff <= (modulus < MOD_W'(2)) ? '0 : rem_ff[ELEM_W-1:0];
      end
   end

   assign rsp_product_value = out_ff;

endmodule

// ===== sv/modular_matrix_product.sv =====
// Top level of the modular matrix product block: registers, controller and datapath.
// A write item is taken while busy stays low, so writes can follow every cycle.
// A read raises busy, walks the fetch and multiply-accumulate over inner_length elements (capped
// at MAX_DIM), runs the remainder unit at two bits a cycle and loads the result register as it
// raises the result strobe; busy stays high until then, and then the next item can follow.
// Reset is synchronous: controller idle, modulus 65537, inner length 16, stores left as is.
module modular_matrix_product #(
   parameter int MAX_DIM = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mmp_pkg::OP_W-1:0]      req_op,
   input  logic [mmp_pkg::IDX_W-1:0]     req_inner_index,
   input  logic [mmp_pkg::IDX_W-1:0]     req_row_index,
   input  logic [mmp_pkg::IDX_W-1:0]     req_col_index,
   input  logic [mmp_pkg::ELEM_W-1:0]    req_value,
   output logic                          rsp_valid,
   output logic [mmp_pkg::ELEM_W-1:0]    rsp_product_value,
   input  logic                          csr_write_en,
   input  logic [mmp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mmp_pkg::CSR_W-1:0]     csr_data
);
   import mmp_pkg::*;

   logic [MOD_W-1:0] modulus_ff;
   logic [LEN_W-1:0] inner_length_ff;
   cmd_type          cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff      <= MODULUS_RESET;
         inner_length_ff <= INNER_LENGTH_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_MODULUS) begin
            modulus_ff <= csr_data[MOD_W-1:0];
         end
         if (csr_index == CSR_INNER_LENGTH) begin
            inner_length_ff <= csr_data[LEN_W-1:0];
         end
      end
   end

   mmp_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_op       (req_op),
      .inner_length (inner_length_ff),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .cmd          (cmd)
   );

   mmp_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .req_inner_index   (req_inner_index),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_value         (req_value),
      .modulus           (modulus_ff),
      .rsp_product_value (rsp_product_value)
   );

endmodule

// ===== sim/modular_matrix_product_tb.sv =====
// Self-checking testbench for the modular matrix product block.
module modular_matrix_product_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mmp_pkg::*;

   localparam int MAX_DIM = 16;
   localparam int DRAIN_CYCLES = 60;
   localparam int DRAIN_LIMIT = 4000;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [ELEM_W-1:0] ELEM_MAX = '1;
   localparam logic [MOD_W-1:0] MOD_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [OP_W-1:0] req_op = '0;
   logic [IDX_W-1:0] req_inner_index = '0;
   logic [IDX_W-1:0] req_row_index = '0;
   logic [IDX_W-1:0] req_col_index = '0;
   logic [ELEM_W-1:0] req_value = '0;
   logic rsp_valid;
   logic [ELEM_W-1:0] rsp_product_value;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;

   // Shadow copies of the block's stores and registers.
   logic [ELEM_W-1:0] client_mem [MAX_DIM*MAX_DIM];
   logic [ELEM_W-1:0] server_mem [MAX_DIM*MAX_DIM];
   logic [MOD_W-1:0] modulus_reg = MODULUS_RESET;
   logic [LEN_W-1:0] inner_length_reg = INNER_LENGTH_RESET;

   logic [ELEM_W-1:0] expected_products [$];
   logic [ELEM_W-1:0] expected_value;
   int fail_count = 0;

   modular_matrix_product #(
      .MAX_DIM(MAX_DIM)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_inner_index(req_inner_index),
      .req_row_index(req_row_index),
      .req_col_index(req_col_index),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_product_value(rsp_product_value),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [ELEM_W-1:0] predict_product(logic [IDX_W-1:0] row,
                                                         logic [IDX_W-1:0] col);
      logic [63:0] m;
      logic [63:0] acc;
      logic [63:0] term;
      int len;
      m = 64'(modulus_reg);
      len = (inner_length_reg > MAX_DIM) ? MAX_DIM : int'(inner_length_reg);
      acc = '0;
      // A modulus below two forces a zero result.
      if (m >= 2) begin
         for (int k = 0; k < len; k++) begin
            term = 64'(server_mem[k*MAX_DIM + row]) * 64'(client_mem[k*MAX_DIM + col]);
            acc = (acc + term % m) % m;
         end
      end
      return acc[ELEM_W-1:0];
   endfunction

   function automatic logic [ELEM_W-1:0] random_element();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         return ELEM_MAX;
      end else if (pick == 1) begin
         return '0;
      end
      return ELEM_W'($urandom);
   endfunction

   // Holds start high until the transfer happens, then updates the shadow state.
   task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] n,
                            logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                            logic [ELEM_W-1:0] value);
      @(negedge clock);
      start <= 1'b1;
      req_op <= op;
      req_inner_index <= n;
      req_row_index <= row;
      req_col_index <= col;
      req_value <= value;
      do begin
         @(posedge clock);
      end while (busy);
      case (op)
         OP_WR_CLIENT: client_mem[{n, col}] = value;
         OP_WR_SERVER: server_mem[{n, row}] = value;
         OP_RD_PRODUCT: expected_products.push_back(predict_product(row, col));
         default: ;
      endcase
   endtask

   task automatic pause_sender(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic maybe_idle(bit allow_idle);
      if (allow_idle && $urandom_range(0, 6) == 0) begin
         pause_sender($urandom_range(1, 16));
      end
   endtask

   task automatic wait_results_done();
      int guard;
      guard = 0;
      while (expected_products.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // Lets every pending read finish so that the registers may be rewritten.
   task automatic drain_block();
      @(negedge clock);
      start <= 1'b0;
      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      if (idx == CSR_MODULUS) begin
         modulus_reg = data[MOD_W-1:0];
      end else begin
         inner_length_reg = data[LEN_W-1:0];
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic read_random();
      send_item(OP_RD_PRODUCT, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                random_element());
   endtask

   // Every entry is written once so that no read ever touches undefined storage.
   task automatic test_fill_stores();
      for (int n = 0; n < MAX_DIM; n++) begin
         for (int i = 0; i < MAX_DIM; i++) begin
            send_item(OP_WR_CLIENT, IDX_W'(n), IDX_W'($urandom), IDX_W'(i), random_element());
            maybe_idle(1'b1);
            send_item(OP_WR_SERVER, IDX_W'(n), IDX_W'(i), IDX_W'($urandom), random_element());
            maybe_idle(1'b1);
         end
      end
   endtask

   task automatic test_field_extremes();
      send_item(OP_WR_CLIENT, '1, '0, '1, ELEM_MAX);
      send_item(OP_WR_SERVER, '1, '1, '0, ELEM_MAX);
      send_item(OP_WR_CLIENT, '0, '1, '0, '0);
      send_item(OP_WR_SERVER, '0, '0, '1, '0);
      send_item(OP_RD_PRODUCT, '0, '1, '1, '0);
      send_item(OP_RD_PRODUCT, '1, '0, '0, ELEM_MAX);
      send_item(OP_RD_PRODUCT, '0, '0, '1, '0);
      // The unused operation code must neither write nor answer.
      send_item(OP_UNUSED, '1, '1, '1, '0);
      send_item(OP_UNUSED, '0, '0, '0, ELEM_MAX);
      send_item(OP_RD_PRODUCT, '0, '1, '1, '0);
   endtask

   task automatic test_modulus_extremes();
      logic [MOD_W-1:0] moduli [6];
      moduli = '{31'd2, 31'h4000_0000, MOD_MAX, 31'd0, 31'd1, MODULUS_RESET};
      foreach (moduli[i]) begin
         drain_block();
         write_csr(CSR_MODULUS, CSR_W'(moduli[i]));
         send_item(OP_RD_PRODUCT, '0, '1, '1, '0);
         read_random();
      end
   endtask

   task automatic test_inner_length_extremes();
      logic [LEN_W-1:0] lengths [6];
      lengths = '{5'd0, 5'd1, 5'd17, '1, 5'd16, INNER_LENGTH_RESET};
      foreach (lengths[i]) begin
         drain_block();
         write_csr(CSR_INNER_LENGTH, CSR_W'(lengths[i]));
         read_random();
      end
   endtask

   // The sender holds off until the block has answered everything, then sends back to back.
   task automatic test_sender_pause();
      read_random();
      @(negedge clock);
      start <= 1'b0;
      wait_results_done();
      read_random();
      send_item(OP_WR_CLIENT, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                random_element());
      read_random();
   endtask

   task automatic test_random_phase(int count, logic [MOD_W-1:0] modulus,
                                    logic [LEN_W-1:0] inner_length, bit allow_idle);
      int pick;
      drain_block();
      write_csr(CSR_MODULUS, CSR_W'(modulus));
      write_csr(CSR_INNER_LENGTH, CSR_W'(inner_length));
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                      random_element());
         end else if (pick < 45) begin
            read_random();
         end else if (pick < 72) begin
            send_item(OP_WR_CLIENT, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                      random_element());
         end else begin
            send_item(OP_WR_SERVER, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                      random_element());
         end
         maybe_idle(allow_idle);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_products.size() == 0) begin
            $error("product_value: no result expected, actual %0d", rsp_product_value);
            fail_count++;
         end else begin
            expected_value = expected_products.pop_front();
            if (rsp_product_value !== expected_value) begin
               $error("product_value: expected %0d, actual %0d", expected_value,
                      rsp_product_value);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_fill_stores();
      test_field_extremes();
      test_modulus_extremes();
      test_inner_length_extremes();
      test_sender_pause();
      test_random_phase(30, MODULUS_RESET, 5'd16, 1'b1);
      test_random_phase(25, 31'd2, 5'd1, 1'b1);
      test_random_phase(25, 31'h4000_0000, 5'd16, 1'b1);
      test_random_phase(25, MOD_MAX, 5'd7, 1'b1);
      test_random_phase(25, 31'($urandom_range(2, 32'h4000_0000)),
                        5'($urandom_range(1, 16)), 1'b1);
      test_random_phase(30, 31'd1_000_003, 5'd16, 1'b0);
      drain_block();
      if (expected_products.size() != 0) begin
         $error("product_value: %0d expected results never arrived", expected_products.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
